### rtl/core/sprite_quad_vertex_setup_defines.svh
// Assertion macros shared by the sprite quad vertex setup RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef SPRITE_QUAD_VERTEX_SETUP_DEFINES_SVH
`define SPRITE_QUAD_VERTEX_SETUP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define SQV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SQV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/sqv_pkg.sv
// Package for the sprite quad vertex setup: request and vertex types,
// register indexes, CORDIC angle table, corner order and saturation.
// No dependencies.
`default_nettype none

package sqv_pkg;

   localparam int VERTS_PER_SPRITE = 6;
   localparam int CORDIC_STEPS = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_VIEWPORT_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VIEWPORT_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXTURE_WIDTH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXTURE_HEIGHT = 3'd3;

   localparam int DIV_NUM_W = 38;
   localparam int DIV_DEN_W = 20;
   localparam int DIV_Q_W = 25;
   localparam int DIV_RES_W = DIV_Q_W + 1;
   localparam int DIV_LAT = DIV_Q_W + 1;

   typedef struct packed {
      logic signed [15:0] dest_x;
      logic signed [15:0] dest_y;
      logic signed [15:0] dest_w;
      logic signed [15:0] dest_h;
      logic [31:0]        rgba;
      logic signed [15:0] turn_angle;
      logic signed [15:0] src_x;
      logic signed [15:0] src_y;
      logic signed [15:0] src_w;
      logic signed [15:0] src_h;
   } sqv_req_type;

   typedef struct packed {
      logic signed [23:0] ndc_x;
      logic signed [23:0] ndc_y;
      logic [31:0]        vertex_rgba;
      logic signed [23:0] tex_u;
      logic signed [23:0] tex_v;
      logic [2:0]         vertex_slot;
      logic               last_vertex;
   } sqv_rsp_type;

   // Arctangent of 2^-i in degrees, Q.16.
   function automatic logic signed [24:0] atan_q16(input int i);
      logic signed [24:0] t;
      unique case (i)
         0: t = 25'sd2949120;
         1: t = 25'sd1740967;
         2: t = 25'sd919879;
         3: t = 25'sd466945;
         4: t = 25'sd234378;
         5: t = 25'sd117303;
         6: t = 25'sd58666;
         7: t = 25'sd29335;
         8: t = 25'sd14668;
         9: t = 25'sd7334;
         10: t = 25'sd3667;
         11: t = 25'sd1833;
         12: t = 25'sd917;
         13: t = 25'sd458;
         14: t = 25'sd229;
         default: t = 25'sd115;
      endcase
      return t;
   endfunction

   // Corner emitted at each vertex slot: 0, 1, 2, 2, 1, 3.
   function automatic logic [1:0] corner_of(input logic [2:0] slot);
      logic [1:0] c;
      unique case (slot)
         3'd0: c = 2'd0;
         3'd1: c = 2'd1;
         3'd2: c = 2'd2;
         3'd3: c = 2'd2;
         3'd4: c = 2'd1;
         default: c = 2'd3;
      endcase
      return c;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
      logic signed [23:0] r;
      if (v > 27'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -27'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/sqv_divider.sv
// Pipelined signed divider with round-to-nearest, ties away from zero.
// One quotient bit per stage, quotient clamped to its width; uses sqv_pkg.
`default_nettype none

module sqv_divider (
   input  wire logic                                   clock,
   input  wire logic                                   en,
   input  wire logic signed [sqv_pkg::DIV_NUM_W-1:0]   num,
   input  wire logic [sqv_pkg::DIV_DEN_W-1:0]          den,
   output logic signed [sqv_pkg::DIV_RES_W-1:0]        quo
);
   import sqv_pkg::*;

   localparam int RW = DIV_NUM_W + 1;
   localparam int TW = DIV_DEN_W + DIV_Q_W;

   logic [RW-1:0]        rem_ff [0:DIV_Q_W];
   logic [DIV_Q_W-1:0]   q_ff [0:DIV_Q_W];
   logic [DIV_DEN_W-1:0] den_ff [0:DIV_Q_W];
   logic                 neg_ff [0:DIV_Q_W];
   logic                 ovf_ff [0:DIV_Q_W];

   logic [DIV_NUM_W-1:0] mag_in;
   logic [RW-1:0]        rem_in;
   logic [DIV_Q_W-1:0]   res;

   assign mag_in = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
   assign rem_in = RW'(mag_in) + RW'(den >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in;
         q_ff[0] <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= num[DIV_NUM_W-1];
         ovf_ff[0] <= TW'(rem_in) >= {den, {DIV_Q_W{1'b0}}};
      end
   end

   for (genvar k = 1; k <= DIV_Q_W; k++) begin : g_stage
      localparam int B = DIV_Q_W - k;
      logic [TW-1:0] trial;
      logic          take;
      assign trial = TW'(den_ff[k-1]) << B;
      assign take = TW'(rem_ff[k-1]) >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= take ? rem_ff[k-1] - trial[RW-1:0] : rem_ff[k-1];
            q_ff[k] <= q_ff[k-1] | (DIV_Q_W'(take) << B);
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign res = ovf_ff[DIV_Q_W] ? '1 : q_ff[DIV_Q_W];
   assign quo = neg_ff[DIV_Q_W] ? -$signed({1'b0, res}) : $signed({1'b0, res});

endmodule

`default_nettype wire

### rtl/core/sprite_quad_vertex_setup.sv
// Top level of the sprite quad vertex setup: expands each sprite request into
// six vertices through a CORDIC, multiply and divide pipeline.
// Uses sqv_pkg, sqv_divider and sprite_quad_vertex_setup_defines.svh.
//
// Usage: a sprite request is taken on req_data when req_valid is high and
// req_stall is low. The block then sends six vertices on rsp_data, slots 0 to
// 5, corners 0,1,2,2,1,3, with last_vertex set on slot 5. A vertex is taken
// when rsp_valid is high and rsp_stall is low.
// rsp_valid for the first vertex of a sprite rises after the front, angle,
// CORDIC, product and divider stages; the other five follow one per cycle
// unless rsp_stall holds them. Unless held, the front stage issues one vertex a
// cycle to match the output and takes new requests only at slot 5 or when idle.
// Registers are written on the csr port (index 0 viewport width, 1 viewport
// height, 2 texture width, 3 texture height); csr_ready is always high and a zero
// register acts as one. The user writes registers only while no sprite is in
// flight; the block does not enforce it. Reset clears all valid bits and loads
// 1280, 720, 256 and 256. When rsp_stall holds a vertex, the whole pipeline
// holds and req_stall rises; nothing is dropped or repeated.
`default_nettype none

module sprite_quad_vertex_setup (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire sqv_pkg::sqv_req_type              req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output sqv_pkg::sqv_rsp_type                   rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sqv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [sqv_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sqv_pkg::*;

`include "sprite_quad_vertex_setup_defines.svh"

   typedef struct packed {
      logic signed [17:0] cx;
      logic signed [17:0] cy;
      logic signed [16:0] ox;
      logic signed [16:0] oy;
      logic signed [16:0] un;
      logic signed [16:0] vn;
      logic [31:0]        rgba;
      logic [2:0]         slot;
   } side_type;

   logic [12:0] vp_w_ff, vp_h_ff;
   logic [14:0] tx_w_ff, tx_h_ff;
   logic        adv;
   logic        accept;

   // Front stage: holds one sprite and issues its six vertices.
   logic        s0_valid_ff;
   logic [2:0]  slot_ff;
   sqv_req_type sprite_ff;

   // Angle reduction and setup.
   logic        s1_valid_ff, s2_valid_ff;
   logic [16:0] a17_ff;
   logic [3:0]  quot_ff;
   side_type    s1_side_ff;

   // CORDIC stages; index 0 is the reduced angle.
   logic               cv_ff [0:CORDIC_STEPS];
   logic signed [18:0] x_ff [0:CORDIC_STEPS];
   logic signed [18:0] y_ff [0:CORDIC_STEPS];
   logic signed [24:0] z_ff [0:CORDIC_STEPS];
   logic               neg_ff [0:CORDIC_STEPS];
   side_type           cs_ff [0:CORDIC_STEPS];

   logic               s19_valid_ff, s20_valid_ff, s21_valid_ff;
   logic signed [18:0] cos_ff, sin_ff;
   side_type           s19_side_ff, s20_side_ff, s21_side_ff;
   logic signed [35:0] pcx_ff, psy_ff, psx_ff, pcy_ff;
   logic signed [DIV_NUM_W-1:0] xq_ff, yq_ff, uq_ff, vq_ff;

   logic     dv_ff [0:DIV_LAT];
   side_type ds_ff [0:DIV_LAT];

   logic rsp_valid_ff;
   sqv_rsp_type rsp_data_ff;

   logic [DIV_DEN_W-1:0] den_x, den_y, den_u, den_v;
   logic signed [DIV_RES_W-1:0] qx, qy, qu, qv;

   logic [16:0]        a17_in;
   logic [31:0]        amul;
   logic [12:0]        rem_in;
   logic signed [12:0] fold_in;
   logic               neg_in;
   side_type           side_in;
   logic [1:0]         corner;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv || (s0_valid_ff && slot_ff != 3'd5);
   assign accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_w_ff <= 13'd1280;
         vp_h_ff <= 13'd720;
         tx_w_ff <= 15'd256;
         tx_h_ff <= 15'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_VIEWPORT_WIDTH: vp_w_ff <= csr_wdata[12:0];
            CSR_VIEWPORT_HEIGHT: vp_h_ff <= csr_wdata[12:0];
            CSR_TEXTURE_WIDTH: tx_w_ff <= csr_wdata[14:0];
            CSR_TEXTURE_HEIGHT: tx_h_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         slot_ff <= '0;
      end else if (adv) begin
         if (s0_valid_ff && slot_ff != 3'd5) begin
            slot_ff <= slot_ff + 3'd1;
         end else if (accept) begin
            s0_valid_ff <= 1'b1;
            slot_ff <= '0;
         end else begin
            s0_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sprite_ff <= req_data;
      end
   end

   // Stage 1: angle mod 5760 by reciprocal, center, offsets, texture edges.
   assign corner = corner_of(slot_ff);
   assign a17_in = 17'({{2{sprite_ff.turn_angle[15]}}, sprite_ff.turn_angle} + 18'd34560);
   assign amul = a17_in * 15'd23302;

   always_comb begin
      side_in.cx = (18'(sprite_ff.dest_x) <<< 1) + 18'(sprite_ff.dest_w);
      side_in.cy = (18'(sprite_ff.dest_y) <<< 1) + 18'(sprite_ff.dest_h);
      side_in.ox = corner[0] ? 17'(sprite_ff.dest_w) : -17'(sprite_ff.dest_w);
      side_in.oy = corner[1] ? 17'(sprite_ff.dest_h) : -17'(sprite_ff.dest_h);
      side_in.un = corner[0] ? 17'(sprite_ff.src_x) + 17'(sprite_ff.src_w)
                             : 17'(sprite_ff.src_x);
      side_in.vn = corner[1] ? 17'(sprite_ff.src_y) + 17'(sprite_ff.src_h)
                             : 17'(sprite_ff.src_y);
      side_in.rgba = sprite_ff.rgba;
      side_in.slot = slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a17_ff <= a17_in;
         quot_ff <= amul[30:27];
         s1_side_ff <= side_in;
      end
   end

   // Stage 2: remainder and fold into -90..90 degrees.
   assign rem_in = 13'(a17_ff - 17'(17'(quot_ff) * 17'd5760));

   always_comb begin
      if (rem_in > 13'd1440 && rem_in < 13'd4320) begin
         fold_in = $signed(rem_in - 13'd2880);
         neg_in = 1'b1;
      end else if (rem_in >= 13'd4320) begin
         fold_in = $signed(rem_in - 13'd5760);
         neg_in = 1'b0;
      end else begin
         fold_in = $signed(rem_in);
         neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign cv_ff[0] = s2_valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0] <= 19'sd39797;
         y_ff[0] <= '0;
         z_ff[0] <= {fold_in, 12'b0};
         neg_ff[0] <= neg_in;
         cs_ff[0] <= s1_side_ff;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [18:0] xs, ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!z_ff[i][24]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - atan_q16(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + atan_q16(i);
            end
            neg_ff[i+1] <= neg_ff[i];
            cs_ff[i+1] <= cs_ff[i];
         end
      end
   end

   // Sign fix, products, corner sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         s19_valid_ff <= 1'b0;
         s20_valid_ff <= 1'b0;
         s21_valid_ff <= 1'b0;
      end else if (adv) begin
         s19_valid_ff <= cv_ff[CORDIC_STEPS];
         s20_valid_ff <= s19_valid_ff;
         s21_valid_ff <= s20_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= neg_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
         sin_ff <= neg_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
         s19_side_ff <= cs_ff[CORDIC_STEPS];

         pcx_ff <= cos_ff * s19_side_ff.ox;
         psy_ff <= sin_ff * s19_side_ff.oy;
         psx_ff <= sin_ff * s19_side_ff.ox;
         pcy_ff <= cos_ff * s19_side_ff.oy;
         s20_side_ff <= s19_side_ff;

         xq_ff <= (DIV_NUM_W'(s20_side_ff.cx) <<< 16) + DIV_NUM_W'(pcx_ff)
                  - DIV_NUM_W'(psy_ff);
         yq_ff <= (DIV_NUM_W'(s20_side_ff.cy) <<< 16) + DIV_NUM_W'(psx_ff)
                  + DIV_NUM_W'(pcy_ff);
         uq_ff <= DIV_NUM_W'(s20_side_ff.un) <<< 10;
         vq_ff <= DIV_NUM_W'(s20_side_ff.vn) <<< 10;
         s21_side_ff <= s20_side_ff;
      end
   end

   assign den_x = {1'b0, (vp_w_ff == '0) ? 13'd1 : vp_w_ff, 6'b0};
   assign den_y = {1'b0, (vp_h_ff == '0) ? 13'd1 : vp_h_ff, 6'b0};
   assign den_u = DIV_DEN_W'((tx_w_ff == '0) ? 15'd1 : tx_w_ff);
   assign den_v = DIV_DEN_W'((tx_h_ff == '0) ? 15'd1 : tx_h_ff);

   sqv_divider u_div_x (.clock(clock), .en(adv), .num(xq_ff), .den(den_x), .quo(qx));
   sqv_divider u_div_y (.clock(clock), .en(adv), .num(yq_ff), .den(den_y), .quo(qy));
   sqv_divider u_div_u (.clock(clock), .en(adv), .num(uq_ff), .den(den_u), .quo(qu));
   sqv_divider u_div_v (.clock(clock), .en(adv), .num(vq_ff), .den(den_v), .quo(qv));

   assign dv_ff[0] = s21_valid_ff;
   assign ds_ff[0] = s21_side_ff;

   for (genvar j = 0; j < DIV_LAT; j++) begin : g_delay
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[j+1] <= dv_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            ds_ff[j+1] <= ds_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_ff[DIV_LAT];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.ndc_x <= sat24(27'(qx) - 27'sd16384);
         rsp_data_ff.ndc_y <= sat24(27'sd16384 - 27'(qy));
         rsp_data_ff.vertex_rgba <= ds_ff[DIV_LAT].rgba;
         rsp_data_ff.tex_u <= sat24(27'(qu));
         rsp_data_ff.tex_v <= sat24(27'(qv));
         rsp_data_ff.vertex_slot <= ds_ff[DIV_LAT].slot;
         rsp_data_ff.last_vertex <= ds_ff[DIV_LAT].slot == 3'd5;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `SQV_ASSERT_NEXT(a_accept_starts_slot0, accept, s0_valid_ff && slot_ff == 3'd0,
      "sprite request taken but slot 0 not issued")
   `SQV_ASSERT_NOW(a_slot_range, s0_valid_ff, slot_ff <= 3'd5,
      "vertex slot out of range")
   `SQV_ASSERT_NOW(a_last_on_slot5, rsp_valid_ff,
      rsp_data_ff.last_vertex == (rsp_data_ff.vertex_slot == 3'd5),
      "last_vertex does not match slot 5")

endmodule

`default_nettype wire

### tb/sv/sprite_quad_vertex_setup_tb.sv
// Self-checking testbench for sprite_quad_vertex_setup: random and directed sprite
// requests, register changes between phases, random rsp_stall and request gaps.
// Depends on sqv_pkg and the sprite_quad_vertex_setup RTL.
`timescale 1ns / 100ps

module sprite_quad_vertex_setup_tb;
   import sqv_pkg::*;

   class vertex_scoreboard;
      longint view_w, view_h, tex_w, tex_h;
      sqv_rsp_type vertex_q[$];
      int errors, sprites, vertices;
      longint atan_deg[16] = '{2949120, 1740967, 919879, 466945, 234378, 117303, 58666,
         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

      function void set_defaults();
         view_w = 1280; view_h = 720; tex_w = 256; tex_h = 256;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_VIEWPORT_WIDTH: view_w = longint'(val & 16'h1FFF);
            CSR_VIEWPORT_HEIGHT: view_h = longint'(val & 16'h1FFF);
            CSR_TEXTURE_WIDTH: tex_w = longint'(val & 16'h7FFF);
            CSR_TEXTURE_HEIGHT: tex_h = longint'(val & 16'h7FFF);
            default: ;
         endcase
      endfunction

      function longint div_round(longint num, longint den);
         if (num >= 0) return (num + den / 2) / den;
         return -((-num + den / 2) / den);
      endfunction

      function longint clamp24(longint v);
         if (v > 8388607) return 8388607;
         if (v < -8388608) return -8388608;
         return v;
      endfunction

      function void rotate_terms(longint ang, output longint c, output longint s);
         longint a, x, y, z, xs, ys;
         bit neg;
         a = ang % 5760;
         if (a < 0) a += 5760;
         neg = 0;
         if (a > 1440 && a < 4320) begin
            a -= 2880;
            neg = 1;
         end else if (a >= 4320) begin
            a -= 5760;
         end
         x = 39797; y = 0; z = a * 4096;
         for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x -= ys; y += xs; z -= atan_deg[i];
            end else begin
               x += ys; y -= xs; z += atan_deg[i];
            end
         end
         c = neg ? -x : x;
         s = neg ? -y : y;
      endfunction

      function void note_request(sqv_req_type r);
         longint c, s, cx, cy, vw, vh, tw, th, ox, oy, xq, yq, u0, u1, v0, v1;
         longint nx[4], ny[4];
         logic [1:0] cn;
         sqv_rsp_type v;
         vw = view_w == 0 ? 1 : view_w;
         vh = view_h == 0 ? 1 : view_h;
         tw = tex_w == 0 ? 1 : tex_w;
         th = tex_h == 0 ? 1 : tex_h;
         rotate_terms(longint'(r.turn_angle), c, s);
         cx = (2 * longint'(r.dest_x) + longint'(r.dest_w)) * 65536;
         cy = (2 * longint'(r.dest_y) + longint'(r.dest_h)) * 65536;
         u0 = clamp24(div_round(longint'(r.src_x) * 1024, tw));
         u1 = clamp24(div_round((longint'(r.src_x) + longint'(r.src_w)) * 1024, tw));
         v0 = clamp24(div_round(longint'(r.src_y) * 1024, th));
         v1 = clamp24(div_round((longint'(r.src_y) + longint'(r.src_h)) * 1024, th));
         for (int k = 0; k < 4; k++) begin
            ox = (k & 1) ? longint'(r.dest_w) : -longint'(r.dest_w);
            oy = (k & 2) ? longint'(r.dest_h) : -longint'(r.dest_h);
            xq = cx + c * ox - s * oy;
            yq = cy + s * ox + c * oy;
            nx[k] = clamp24(div_round(xq, 64 * vw) - 16384);
            ny[k] = clamp24(16384 - div_round(yq, 64 * vh));
         end
         for (int k = 0; k < VERTS_PER_SPRITE; k++) begin
            cn = 2'((k == 0) ? 0 : (k == 1 || k == 4) ? 1 : (k == 5) ? 3 : 2);
            v.ndc_x = 24'(nx[cn]);
            v.ndc_y = 24'(ny[cn]);
            v.vertex_rgba = r.rgba;
            v.tex_u = 24'(cn[0] ? u1 : u0);
            v.tex_v = 24'(cn[1] ? v1 : v0);
            v.vertex_slot = 3'(k);
            v.last_vertex = (k == VERTS_PER_SPRITE - 1);
            vertex_q = {vertex_q, v};
         end
         sprites++;
      endfunction

      function void compare(string name, longint e, longint a);
         if (e != a) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
         end
      endfunction

      function void check_vertex(sqv_rsp_type a);
         sqv_rsp_type e;
         vertices++;
         if (vertex_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected vertex, expected none, actual %h", $time, a);
            return;
         end
         e = vertex_q.pop_front();
         compare("ndc_x", longint'(e.ndc_x), longint'(a.ndc_x));
         compare("ndc_y", longint'(e.ndc_y), longint'(a.ndc_y));
         compare("vertex_rgba", longint'(e.vertex_rgba), longint'(a.vertex_rgba));
         compare("tex_u", longint'(e.tex_u), longint'(a.tex_u));
         compare("tex_v", longint'(e.tex_v), longint'(a.tex_v));
         compare("vertex_slot", longint'(e.vertex_slot), longint'(a.vertex_slot));
         compare("last_vertex", longint'(e.last_vertex), longint'(a.last_vertex));
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   sqv_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   sqv_rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   vertex_scoreboard sb = new();
   bit quiet = 0;
   int stall_left = 0;
   int idle_cycles = 0;
   int reg_writes = 0;

   always #2 clock = ~clock;

   sprite_quad_vertex_setup i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_vertex(rsp_data);
      end
      if (reset || quiet) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= int'($urandom_range(0, 5));
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
      if (!reset) begin
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || csr_valid) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= 3000) begin
            $display("%0t: watchdog expired", $time);
            $display("** sprite_quad_vertex_setup: FAILED **");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      reg_writes++;
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.vertex_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic setup_regs(int vw, int vh, int tw, int th);
      drain();
      write_reg(CSR_VIEWPORT_WIDTH, CSR_DATA_W'(vw));
      write_reg(CSR_VIEWPORT_HEIGHT, CSR_DATA_W'(vh));
      write_reg(CSR_TEXTURE_WIDTH, CSR_DATA_W'(tw));
      write_reg(CSR_TEXTURE_HEIGHT, CSR_DATA_W'(th));
   endtask

   task automatic send_request(sqv_req_type r);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = int'($urandom_range(1, 6));
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 8000) - 4000);
         1: return 16'($urandom_range(0, 800) - 400);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic sqv_req_type random_request();
      sqv_req_type r;
      r.dest_x = pick16(); r.dest_y = pick16();
      r.dest_w = pick16(); r.dest_h = pick16();
      r.rgba = $urandom;
      r.turn_angle = 16'($urandom);
      r.src_x = pick16(); r.src_y = pick16();
      r.src_w = pick16(); r.src_h = pick16();
      return r;
   endfunction

   task automatic send_random(int n);
      for (int i = 0; i < n; i++) send_request(random_request());
   endtask

   initial begin
      sqv_req_type r;
      logic [15:0] angles[12];
      angles = '{16'd0, 16'd1440, 16'd1441, 16'd2880, 16'd4319, 16'd4320, 16'd5759,
         16'd5760, 16'hFFFF, 16'h7FFF, 16'h8000, 16'd720};
      sb.set_defaults();
      sb.errors = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      r = '0;
      send_request(r);
      r = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFFFFFF, 16'h7FFF,
            16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
      send_request(r);
      r = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h0, 16'h8000,
            16'h8000, 16'h8000, 16'h8000, 16'h8000};
      send_request(r);
      r = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 32'h12345678, 16'd0,
            16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
      send_request(r);
      foreach (angles[i]) begin
         r = '{16'd1600, 16'd800, 16'd640, -16'sd320, 32'hA5C3_0F96, angles[i],
               16'd16, -16'sd48, 16'd512, -16'sd256};
         send_request(r);
      end
      send_random(60);

      setup_regs(0, 0, 0, 0);
      send_random(60);
      setup_regs(1, 1, 1, 1);
      send_random(60);
      setup_regs(4096, 4096, 16384, 16384);
      send_random(60);
      setup_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      write_reg(3'd4, 16'd7);
      write_reg(3'd7, 16'd9);
      send_random(60);
      setup_regs(640, 480, 512, 64);
      quiet = 1;
      send_random(80);
      drain();

      $display("Checked %0d sprites and %0d vertices over %0d register writes.",
               sb.sprites, sb.vertices, reg_writes);
      $display("Register settings ranged from zero divisors to full width values.");
      if (sb.errors == 0 && sb.vertex_q.size() == 0) begin
         $display("** sprite_quad_vertex_setup: PASSED **");
      end else begin
         $display("** sprite_quad_vertex_setup: FAILED **");
      end
      $finish;
   end
endmodule
